[src/mi3_pkg.sv]
// Package for the 3x3 matrix inverse: widths, word types and pipeline structs.
// Used by every module of the block; depends on nothing.
package mi3_pkg;

  localparam int WORD_BITS = 24;
  localparam int FRAC_BITS = 16;

  // Exact widths of the intermediate values.
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int COF_BITS  = 2 * WORD_BITS + 1;
  localparam int PART_BITS = 2 * WORD_BITS + 1;
  localparam int DET_BITS  = 3 * WORD_BITS + 3;
  localparam int NUM_BITS  = COF_BITS + 2 * FRAC_BITS;
  localparam int QUO_BITS  = WORD_BITS;
  localparam int CMP_BITS  =
      ((NUM_BITS > DET_BITS + QUO_BITS) ? NUM_BITS : DET_BITS + QUO_BITS) + 1;

  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES   = QUO_BITS + 1;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] m00;
    logic signed [WORD_BITS-1:0] m01;
    logic signed [WORD_BITS-1:0] m02;
    logic signed [WORD_BITS-1:0] m10;
    logic signed [WORD_BITS-1:0] m11;
    logic signed [WORD_BITS-1:0] m12;
    logic signed [WORD_BITS-1:0] m20;
    logic signed [WORD_BITS-1:0] m21;
    logic signed [WORD_BITS-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r00;
    logic signed [WORD_BITS-1:0] r01;
    logic signed [WORD_BITS-1:0] r02;
    logic signed [WORD_BITS-1:0] r10;
    logic signed [WORD_BITS-1:0] r11;
    logic signed [WORD_BITS-1:0] r12;
    logic signed [WORD_BITS-1:0] r20;
    logic signed [WORD_BITS-1:0] r21;
    logic signed [WORD_BITS-1:0] r22;
    logic                        singular;
    logic                        overflow;
  } res_t;

  // Front end to divider lanes: magnitudes and signs of the adjugate entries
  // (index i*3+j) and of the determinant.
  typedef struct packed {
    logic [8:0][COF_BITS-1:0] nmag;
    logic [8:0]               rneg;
    logic [DET_BITS-1:0]      dmag;
    logic                     singular;
  } front_t;

  typedef struct packed {
    logic [QUO_BITS-1:0] quo;
    logic                big;
    logic                rneg;
  } lane_t;

endpackage

[src/mi3_front.sv]
// Front end of the inverse: cofactors, determinant and their magnitudes.
// Six register stages; uses mi3_pkg.
module mi3_front
  import mi3_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  mat_t   mat_i,
  output front_t front_o
);

  logic signed [WORD_BITS-1:0] e [3][3];

  assign e[0][0] = mat_i.m00;
  assign e[0][1] = mat_i.m01;
  assign e[0][2] = mat_i.m02;
  assign e[1][0] = mat_i.m10;
  assign e[1][1] = mat_i.m11;
  assign e[1][2] = mat_i.m12;
  assign e[2][0] = mat_i.m20;
  assign e[2][1] = mat_i.m21;
  assign e[2][2] = mat_i.m22;

  logic signed [PROD_BITS-1:0] pa_q [3][3];
  logic signed [PROD_BITS-1:0] pb_q [3][3];
  logic signed [WORD_BITS-1:0] row1_q [3];
  logic signed [WORD_BITS-1:0] row2_q [3];
  logic signed [COF_BITS-1:0]  cof2_q [3][3];
  logic signed [COF_BITS-1:0]  cof3_q [3][3];
  logic signed [COF_BITS-1:0]  cof4_q [3][3];
  logic signed [COF_BITS-1:0]  cof5_q [3][3];
  logic signed [PART_BITS-1:0] hi_q [3];
  logic signed [PART_BITS-1:0] lo_q [3];
  logic signed [DET_BITS-1:0]  term_q [3];
  logic signed [DET_BITS-1:0]  det_q;
  logic signed [DET_BITS-1:0]  det_d;
  front_t                      front_q;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int RA = (j + 1) % 3;
      localparam int RB = (j + 2) % 3;
      localparam int CA = (i + 1) % 3;
      localparam int CB = (i + 2) % 3;
      logic signed [PROD_BITS-1:0] pa_d, pb_d;
      logic signed [COF_BITS-1:0]  cof_d;
      assign pa_d  = PROD_BITS'(e[RA][CA]) * PROD_BITS'(e[RB][CB]);
      assign pb_d  = PROD_BITS'(e[RA][CB]) * PROD_BITS'(e[RB][CA]);
      assign cof_d = COF_BITS'(pa_q[i][j]) - COF_BITS'(pb_q[i][j]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_q[i][j]   <= pa_d;
          pb_q[i][j]   <= pb_d;
          cof2_q[i][j] <= cof_d;
          cof3_q[i][j] <= cof2_q[i][j];
          cof4_q[i][j] <= cof3_q[i][j];
          cof5_q[i][j] <= cof4_q[i][j];
        end
      end
    end

    // Row zero entry times cofactor, split so each product stays narrow.
    logic signed [PART_BITS-1:0] a_ext, hi_op, lo_op, hi_d, lo_d;
    logic signed [DET_BITS-1:0]  term_d;
    assign a_ext  = PART_BITS'(row2_q[i]);
    assign hi_op  = PART_BITS'($signed(cof2_q[i][0][COF_BITS-1:WORD_BITS]));
    assign lo_op  = PART_BITS'($signed({1'b0, cof2_q[i][0][WORD_BITS-1:0]}));
    assign hi_d   = a_ext * hi_op;
    assign lo_d   = a_ext * lo_op;
    assign term_d = (DET_BITS'(hi_q[i]) <<< WORD_BITS) + DET_BITS'(lo_q[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        row1_q[i] <= e[0][i];
        row2_q[i] <= row1_q[i];
        hi_q[i]   <= hi_d;
        lo_q[i]   <= lo_d;
        term_q[i] <= term_d;
      end
    end
  end

  assign det_d = term_q[0] + term_q[1] + term_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= det_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          front_q.nmag[i*3+j] <= cof5_q[i][j][COF_BITS-1] ? COF_BITS'(-cof5_q[i][j])
                                                          : COF_BITS'(cof5_q[i][j]);
          front_q.rneg[i*3+j] <= cof5_q[i][j][COF_BITS-1] ^ det_q[DET_BITS-1];
        end
      end
      front_q.dmag     <= det_q[DET_BITS-1] ? DET_BITS'(-det_q) : DET_BITS'(det_q);
      front_q.singular <= (det_q == '0);
    end
  end

  assign front_o = front_q;

endmodule

[src/mi3_div_lane.sv]
// One pipelined restoring divider lane: one quotient bit per stage plus a
// leading range check. Uses mi3_pkg.
module mi3_div_lane
  import mi3_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [COF_BITS-1:0] nmag_i,
  input  logic                rneg_i,
  input  logic [DET_BITS-1:0] dmag_i,
  output lane_t               lane_o
);

  logic [NUM_BITS-1:0] rem_q  [DIV_STAGES];
  logic [DET_BITS-1:0] dmag_q [DIV_STAGES];
  logic [QUO_BITS-1:0] quo_q  [DIV_STAGES];
  logic                big_q  [DIV_STAGES];
  logic                rneg_q [DIV_STAGES];

  logic [NUM_BITS-1:0] num;
  logic                big_d;

  assign num   = {nmag_i, {(2*FRAC_BITS){1'b0}}};
  // A quotient of 2^QUO_BITS or more saturates whatever its sign.
  assign big_d = CMP_BITS'(num) >= (CMP_BITS'(dmag_i) << QUO_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num;
      dmag_q[0] <= dmag_i;
      quo_q[0]  <= '0;
      big_q[0]  <= big_d;
      rneg_q[0] <= rneg_i;
    end
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
    localparam int K = QUO_BITS - s;
    logic [CMP_BITS-1:0] diff;
    logic                take;
    assign diff = CMP_BITS'(rem_q[s-1]) - (CMP_BITS'(dmag_q[s-1]) << K);
    assign take = !diff[CMP_BITS-1];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? diff[NUM_BITS-1:0] : rem_q[s-1];
        quo_q[s]  <= take ? (quo_q[s-1] | (QUO_BITS'(1) << K)) : quo_q[s-1];
        dmag_q[s] <= dmag_q[s-1];
        big_q[s]  <= big_q[s-1];
        rneg_q[s] <= rneg_q[s-1];
      end
    end
  end

  assign lane_o.quo  = quo_q[DIV_STAGES-1];
  assign lane_o.big  = big_q[DIV_STAGES-1];
  assign lane_o.rneg = rneg_q[DIV_STAGES-1];

endmodule

[src/matrix3x3_inverse_top.sv]
// Top level of the 3x3 matrix inverse: front end, nine divider lanes,
// saturation and output register. Uses mi3_pkg, mi3_front, mi3_div_lane.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_stall_o  | mat_t (m00 .. m22)
//   out     | output    | out_valid_o / out_stall_i | res_t (r00 .. r22, flags)
//
// One matrix enters per cycle while not held, passing LATENCY = 32 register
// stages: six front stages, 25 divider stages (a range check, then one quotient
// bit each) and one output stage.
// Reset clears only the valid bits of the pipeline.
// When the output word waits under stall the whole pipeline holds, and
// in_stall_o follows out_stall_i in that cycle.
module matrix3x3_inverse_top
  import mi3_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  mat_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  logic                  en;
  logic [LATENCY-1:0]    vld_q;
  logic [DIV_STAGES-1:0] sing_q;
  front_t                front;
  lane_t                 lane [9];
  logic [8:0][WORD_BITS-1:0] val;
  logic [8:0]            ovf;
  res_t                  res_d, res_q;

  localparam logic [WORD_BITS-1:0] PosMax = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] NegMin = {1'b1, {(WORD_BITS-1){1'b0}}};

  assign en         = !(vld_q[LATENCY-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
    end
  end

  mi3_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .mat_i   (in_data_i),
    .front_o (front)
  );

  for (genvar l = 0; l < 9; l++) begin : g_lane
    mi3_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .nmag_i (front.nmag[l]),
      .rneg_i (front.rneg[l]),
      .dmag_i (front.dmag),
      .lane_o (lane[l])
    );

    always_comb begin
      if (sing_q[DIV_STAGES-1]) begin
        ovf[l] = 1'b0;
        val[l] = '0;
      end else if (lane[l].rneg) begin
        ovf[l] = lane[l].big || (lane[l].quo[QUO_BITS-1] && |lane[l].quo[QUO_BITS-2:0]);
        val[l] = ovf[l] ? NegMin : WORD_BITS'(-lane[l].quo);
      end else begin
        ovf[l] = lane[l].big || lane[l].quo[QUO_BITS-1];
        val[l] = ovf[l] ? PosMax : lane[l].quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[DIV_STAGES-2:0], front.singular};
    end
  end

  always_comb begin
    res_d.r00      = val[0];
    res_d.r01      = val[1];
    res_d.r02      = val[2];
    res_d.r10      = val[3];
    res_d.r11      = val[4];
    res_d.r12      = val[5];
    res_d.r20      = val[6];
    res_d.r21      = val[7];
    res_d.r22      = val[8];
    res_d.singular = sing_q[DIV_STAGES-1];
    res_d.overflow = |ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[LATENCY-1];
  assign out_data_o  = res_q;

  // A singular result carries no overflow and zero entries; r00 and r22 are checked.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.singular) |->
      (!out_data_o.overflow && out_data_o.r00 == '0 && out_data_o.r22 == '0))
    else $error("singular result with nonzero content");

  // Overflow implies at least one entry sits at a saturation bound.
  a_overflow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |->
      (out_data_o.r00 == PosMax || out_data_o.r00 == NegMin ||
       out_data_o.r01 == PosMax || out_data_o.r01 == NegMin ||
       out_data_o.r02 == PosMax || out_data_o.r02 == NegMin ||
       out_data_o.r10 == PosMax || out_data_o.r10 == NegMin ||
       out_data_o.r11 == PosMax || out_data_o.r11 == NegMin ||
       out_data_o.r12 == PosMax || out_data_o.r12 == NegMin ||
       out_data_o.r20 == PosMax || out_data_o.r20 == NegMin ||
       out_data_o.r21 == PosMax || out_data_o.r21 == NegMin ||
       out_data_o.r22 == PosMax || out_data_o.r22 == NegMin))
    else $error("overflow flagged without a saturated entry");

  // A word in the stage before the output is not lost while the pipeline is held.
  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LATENCY-2] && in_stall_o) |=> vld_q[LATENCY-2])
    else $error("pipeline word dropped during stall");

endmodule

[sim/tb_top.sv]
// Testbench for the 3x3 matrix inverse: random and directed matrices, checked
// against an exact adjugate/determinant predictor. Depends on mi3_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top
  import mi3_pkg::*;
();

  class inverse_board;
    res_t pending_q[$];
    int   errors;

    function res_t invert(mat_t m);
      logic signed [WORD_BITS-1:0] e [3][3];
      logic signed [127:0] cof [3][3];
      logic signed [127:0] det, num, q, dmag;
      logic signed [127:0] pmax, nmin;
      res_t r;
      logic signed [WORD_BITS-1:0] v [9];
      int i, j;
      e[0][0] = m.m00; e[0][1] = m.m01; e[0][2] = m.m02;
      e[1][0] = m.m10; e[1][1] = m.m11; e[1][2] = m.m12;
      e[2][0] = m.m20; e[2][1] = m.m21; e[2][2] = m.m22;
      // Entry (i,j) of the adjugate is the (j,i) cofactor.
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++)
          cof[i][j] = 128'(e[(j+1)%3][(i+1)%3]) * 128'(e[(j+2)%3][(i+2)%3])
                    - 128'(e[(j+1)%3][(i+2)%3]) * 128'(e[(j+2)%3][(i+1)%3]);
      det = 0;
      for (i = 0; i < 3; i++) det += 128'(e[0][i]) * cof[i][0];
      r = '0;
      if (det == 0) begin
        r.singular = 1'b1;
        return r;
      end
      pmax = (128'sd1 <<< (WORD_BITS - 1)) - 1;
      nmin = -(128'sd1 <<< (WORD_BITS - 1));
      dmag = det < 0 ? -det : det;
      for (i = 0; i < 9; i++) begin
        num = cof[i/3][i%3];
        // Divide magnitudes so the quotient truncates toward zero.
        q = ((num < 0 ? -num : num) <<< (2 * FRAC_BITS)) / dmag;
        if ((num < 0) != (det < 0)) q = -q;
        if (q > pmax) begin q = pmax; r.overflow = 1'b1; end
        if (q < nmin) begin q = nmin; r.overflow = 1'b1; end
        v[i] = q[WORD_BITS-1:0];
      end
      r.r00 = v[0]; r.r01 = v[1]; r.r02 = v[2];
      r.r10 = v[3]; r.r11 = v[4]; r.r12 = v[5];
      r.r20 = v[6]; r.r21 = v[7]; r.r22 = v[8];
      return r;
    endfunction

    function void note_matrix(mat_t m);
      pending_q.push_back(invert(m));
    endfunction

    function void check_result(res_t a);
      res_t x;
      if (pending_q.size() == 0) begin
        $error("result word with no matrix pending");
        errors++;
        return;
      end
      x = pending_q.pop_front();
      if (a.r00 !== x.r00) begin $error("r00 exp %h got %h", x.r00, a.r00); errors++; end
      if (a.r01 !== x.r01) begin $error("r01 exp %h got %h", x.r01, a.r01); errors++; end
      if (a.r02 !== x.r02) begin $error("r02 exp %h got %h", x.r02, a.r02); errors++; end
      if (a.r10 !== x.r10) begin $error("r10 exp %h got %h", x.r10, a.r10); errors++; end
      if (a.r11 !== x.r11) begin $error("r11 exp %h got %h", x.r11, a.r11); errors++; end
      if (a.r12 !== x.r12) begin $error("r12 exp %h got %h", x.r12, a.r12); errors++; end
      if (a.r20 !== x.r20) begin $error("r20 exp %h got %h", x.r20, a.r20); errors++; end
      if (a.r21 !== x.r21) begin $error("r21 exp %h got %h", x.r21, a.r21); errors++; end
      if (a.r22 !== x.r22) begin $error("r22 exp %h got %h", x.r22, a.r22); errors++; end
      if (a.singular !== x.singular) begin
        $error("singular exp %b got %b", x.singular, a.singular); errors++;
      end
      if (a.overflow !== x.overflow) begin
        $error("overflow exp %b got %b", x.overflow, a.overflow); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;
  logic hold_long = 1'b0;

  inverse_board board = new();
  mat_t directed_q[$];

  matrix3x3_inverse_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [WORD_BITS-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      1: return 24'($signed($urandom_range(0, 600)) - 300);
      2: return 24'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t m;
    m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
         rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    // Some matrices get a repeated row so the determinant is zero.
    if ($urandom_range(0, 9) == 0) begin
      m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
    end
    return m;
  endfunction

  // Offers one word and holds it until the block takes it.
  task automatic send_matrix(mat_t m);
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (in_stall);
    board.note_matrix(m);
  endtask

  task automatic add_diag(int a, int b, int c);
    mat_t m;
    m = '0;
    m.m00 = 24'(a); m.m11 = 24'(b); m.m22 = 24'(c);
    directed_q.push_back(m);
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) board.check_result(out_data);
  end

  // Receiver stall pattern, with one long hold while the sender keeps going.
  initial begin
    int phase;
    bit long_done;
    long_done = 1'b0;
    @(posedge rst_n);
    for (phase = 0; ; phase++) begin
      if (hold_long && !long_done) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        long_done = 1'b1;
      end
      case ((phase / 200) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
      @(posedge clk);
    end
  end

  initial begin
    int n, gap, burst, wait_cycles;
    mat_t m;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_diag(1 << 16, 1 << 16, 1 << 16);
    add_diag(2 << 16, 4 << 16, -(8 << 16));
    add_diag(1, 1, 1);
    add_diag(-1, 1, -1);
    add_diag(24'h7fffff, 24'h7fffff, 24'h7fffff);
    add_diag(-8388608, -8388608, -8388608);
    add_diag(1 << 16, 1, 1 << 16);
    directed_q.push_back('0);
    m = '1; directed_q.push_back(m);
    m = {24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
         24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff};
    directed_q.push_back(m);
    m = {24'sh000001, 24'sh7fffff, 24'sh0, 24'sh0, 24'sh000001, 24'sh7fffff,
         24'sh0, 24'sh0, 24'sh000001};
    directed_q.push_back(m);
    for (n = 0; n < 8; n++) directed_q.push_back(rand_matrix());
    foreach (directed_q[k]) send_matrix(directed_q[k]);
    n = 0;
    while (n < 650) begin
      burst = $urandom_range(1, 40);
      if (n >= 300) hold_long = 1'b1;
      for (int k = 0; k < burst && n < 650; k++) begin
        send_matrix(rand_matrix());
        n++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (board.pending_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
